FILE: hdl/vas_pkg.sv
// ----------------------------------------------------------------------------
// Voice allocator package
// Field widths, request kinds, allocation actions and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vas_pkg;

   localparam int KIND_W   = 3;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int CHAN_W   = 4;
   localparam int VOICE_W  = 5;
   localparam int LEVEL_W  = 16;
   localparam int CFG_W    = 6;
   localparam int ACTION_W = 3;
   localparam int COUNT_W  = 6;

   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ALL_OFF  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LEVEL    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FINISHED = 3'd4;

   localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_RETRIGGER = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FREE      = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_STEAL_REL = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_STEAL_QT  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_STEAL_OLD = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_QUIET,
      ST_START,
      ST_RELEASE,
      ST_RECOUNT,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/vas_if.sv
// ----------------------------------------------------------------------------
// Voice allocator channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vas_req_if;
   import vas_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [NOTE_W-1:0]  note;
   logic [VEL_W-1:0]   velocity;
   logic [CHAN_W-1:0]  channel;
   logic [VOICE_W-1:0] voice;
   logic [LEVEL_W-1:0] level;

   modport source (output valid, kind, note, velocity, channel, voice, level, input ready);
   modport sink (input valid, kind, note, velocity, channel, voice, level, output ready);
endinterface

interface vas_rsp_if;
   import vas_pkg::*;

   logic                valid;
   logic                ready;
   logic [VOICE_W-1:0]  chosen_voice;
   logic [ACTION_W-1:0] action;
   logic [COUNT_W-1:0]  released_count;
   logic [COUNT_W-1:0]  active_count;

   modport source (output valid, chosen_voice, action, released_count, active_count,
                   input ready);
   modport sink (input valid, chosen_voice, action, released_count, active_count,
                 output ready);
endinterface

interface vas_csr_if;
   import vas_pkg::*;

   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: hdl/voice_allocator_with_stealing_unit.sv
// ----------------------------------------------------------------------------
// Voice allocator with stealing
// A note on is answered after a scan of the voices. When a voice is stolen, a
// second pass over the voices is needed. Note off and all notes off are
// answered after one pass; level reports and voice-finished events need no
// scan. One request is in work at a time, and the next is taken only once the
// response is issued. The single read port of the voice memories, scanned one
// voice per cycle, sets the rate. A response that the sink has not yet taken
// holds the next response back.
// Reset clears the voice flags, the age counter and the active count and sets
// the polyphony to MAX_VOICES or 32, whichever is smaller; the voice memories
// are not cleared. A polyphony write is taken only while idle. It starts a
// recount of the active voices, during which no request is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voice_allocator_with_stealing_unit #(
   parameter int MAX_VOICES = 32,
   parameter int AGE_BITS   = 32,
   parameter int LEVEL_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   vas_req_if.sink   req_chan,
   vas_rsp_if.source rsp_chan,
   vas_csr_if.sink   csr_chan
);
   import vas_pkg::*;

   localparam int VW       = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CW       = $clog2(MAX_VOICES + 1);
   localparam int POLY_RST = (MAX_VOICES < 32) ? MAX_VOICES : 32;

   typedef struct packed {
      logic [NOTE_W-1:0]   note;
      logic [CHAN_W-1:0]   chan;
      logic [AGE_BITS-1:0] age;
   } ident_type;

   function automatic logic [CW-1:0] clamp_poly(input logic [CFG_W-1:0] raw);
      logic [CW-1:0] p;
      if (raw == '0) begin
         p = CW'(1);
      end else if (int'(raw) > MAX_VOICES) begin
         p = CW'(MAX_VOICES);
      end else begin
         p = CW'(raw);
      end
      return p;
   endfunction

   ident_type             ident_mem [MAX_VOICES];
   logic [LEVEL_BITS-1:0] level_mem [MAX_VOICES];
   ident_type             id_rd_ff;
   logic [LEVEL_BITS-1:0] lv_rd_ff;

   logic                  id_we;
   ident_type             id_wd;
   logic                  lv_we;
   logic [VW-1:0]         lv_wa;
   logic [LEVEL_BITS-1:0] lv_wd;
   logic [VW-1:0]         rd_addr;

   state_type state_ff, state_in;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;

   logic [CW-1:0]         poly_ff, poly_in;
   logic [MAX_VOICES-1:0] active_ff, active_in;
   logic [MAX_VOICES-1:0] rel_ff, rel_in;
   logic [AGE_BITS-1:0]   age_ctr_ff, age_ctr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;

   logic [CW-1:0] idx_ff, idx_in;
   logic          rdv_ff, rdv_in;
   logic [VW-1:0] idx_d_ff, idx_d_in;

   logic                  match_found_ff, match_found_in;
   logic [VW-1:0]         match_idx_ff, match_idx_in;
   logic                  free_found_ff, free_found_in;
   logic [VW-1:0]         free_idx_ff, free_idx_in;
   logic [AGE_BITS-1:0]   newest_ff, newest_in;
   logic [AGE_BITS-1:0]   oldest_ff, oldest_in;
   logic [VW-1:0]         oldest_idx_ff, oldest_idx_in;
   logic [CW-1:0]         scan_cnt_ff, scan_cnt_in;
   logic                  qr_found_ff, qr_found_in;
   logic [VW-1:0]         qr_idx_ff, qr_idx_in;
   logic [LEVEL_BITS-1:0] qr_lvl_ff, qr_lvl_in;
   logic [AGE_BITS-1:0]   qr_age_ff, qr_age_in;
   logic                  qa_found_ff, qa_found_in;
   logic [VW-1:0]         qa_idx_ff, qa_idx_in;
   logic [LEVEL_BITS-1:0] qa_lvl_ff, qa_lvl_in;
   logic [AGE_BITS-1:0]   qa_age_ff, qa_age_in;
   logic [CW-1:0]         rel_cnt_ff, rel_cnt_in;
   logic [VW-1:0]         chosen_ff, chosen_in;
   logic [ACTION_W-1:0]   act_ff, act_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VOICE_W-1:0]  rsp_chosen_ff, rsp_chosen_in;
   logic [ACTION_W-1:0] rsp_action_ff, rsp_action_in;
   logic [COUNT_W-1:0]  rsp_rel_ff, rsp_rel_in;
   logic [COUNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic                req_fire;
   logic                csr_fire;
   logic                issue_ok;
   logic                last_eval;
   logic                out_free;
   logic                cur_act;
   logic                cur_rel;
   logic                id_match;
   logic                match_hit;
   logic                free_hit;
   logic                skip_newest;
   logic [CW-1:0]       new_poly;
   logic [VW-1:0]       req_vidx;
   logic                req_in_range;
   logic [AGE_BITS-1:0] age_next;

   assign req_fire     = req_chan.valid && req_chan.ready;
   assign csr_fire     = csr_chan.valid && csr_chan.ready;
   assign issue_ok     = idx_ff < poly_ff;
   assign last_eval    = rdv_ff && (CW'(idx_d_ff) == (poly_ff - CW'(1)));
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign cur_act      = active_ff[idx_d_ff];
   assign cur_rel      = rel_ff[idx_d_ff];
   assign id_match     = (id_rd_ff.note == note_ff) && (id_rd_ff.chan == chan_ff);
   assign match_hit    = rdv_ff && cur_act && id_match && !match_found_ff;
   assign free_hit     = rdv_ff && !cur_act && !free_found_ff;
   assign skip_newest  = (id_rd_ff.age == newest_ff) && (poly_ff > CW'(1));
   assign new_poly     = clamp_poly(csr_chan.data);
   assign req_vidx     = VW'(req_chan.voice);
   assign req_in_range = int'(req_chan.voice) < int'(poly_ff);
   assign age_next     = (age_ctr_ff == '1) ? age_ctr_ff : age_ctr_ff + AGE_BITS'(1);
   assign rd_addr      = idx_ff[VW-1:0];

   assign req_chan.ready          = (state_ff == ST_IDLE) && !csr_chan.valid;
   assign csr_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.chosen_voice   = rsp_chosen_ff;
   assign rsp_chan.action         = rsp_action_ff;
   assign rsp_chan.released_count = rsp_rel_ff;
   assign rsp_chan.active_count   = rsp_cnt_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == KIND_NOTE_ON && req_chan.velocity != '0) begin
                  state_in = ST_SCAN;
               end else if (req_chan.kind == KIND_NOTE_ON || req_chan.kind == KIND_NOTE_OFF ||
                            req_chan.kind == KIND_ALL_OFF) begin
                  state_in = ST_RELEASE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (last_eval) begin
               if (match_found_ff || match_hit || free_found_ff || free_hit) begin
                  state_in = ST_START;
               end else begin
                  state_in = ST_QUIET;
               end
            end
         end
         ST_QUIET: begin
            if (last_eval) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DONE;
         end
         ST_RELEASE: begin
            if (last_eval) begin
               state_in = ST_DONE;
            end
         end
         ST_RECOUNT: begin
            if (!issue_ok) begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_fire) begin
         state_in = ST_RECOUNT;
      end
   end

   always_comb begin
      kind_in        = kind_ff;
      note_in        = note_ff;
      chan_in        = chan_ff;
      poly_in        = poly_ff;
      active_in      = active_ff;
      rel_in         = rel_ff;
      age_ctr_in     = age_ctr_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      rdv_in         = 1'b0;
      idx_d_in       = idx_d_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      newest_in      = newest_ff;
      oldest_in      = oldest_ff;
      oldest_idx_in  = oldest_idx_ff;
      scan_cnt_in    = scan_cnt_ff;
      qr_found_in    = qr_found_ff;
      qr_idx_in      = qr_idx_ff;
      qr_lvl_in      = qr_lvl_ff;
      qr_age_in      = qr_age_ff;
      qa_found_in    = qa_found_ff;
      qa_idx_in      = qa_idx_ff;
      qa_lvl_in      = qa_lvl_ff;
      qa_age_in      = qa_age_ff;
      rel_cnt_in     = rel_cnt_ff;
      chosen_in      = chosen_ff;
      act_in         = act_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_chosen_in  = rsp_chosen_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_rel_in     = rsp_rel_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      id_we          = 1'b0;
      id_wd          = '{note: note_ff, chan: chan_ff, age: age_next};
      lv_we          = 1'b0;
      lv_wa          = chosen_ff;
      lv_wd          = '0;

      if ((state_ff == ST_SCAN || state_ff == ST_QUIET || state_ff == ST_RELEASE) &&
          issue_ok) begin
         rdv_in   = 1'b1;
         idx_d_in = idx_ff[VW-1:0];
         idx_in   = idx_ff + CW'(1);
      end
      if (last_eval) begin
         idx_in = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in        = req_chan.kind;
               note_in        = req_chan.note;
               chan_in        = req_chan.channel;
               idx_in         = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               newest_in      = '0;
               scan_cnt_in    = '0;
               qr_found_in    = 1'b0;
               qa_found_in    = 1'b0;
               rel_cnt_in     = '0;
               chosen_in      = '0;
               act_in         = ACT_NONE;
               if (req_chan.kind == KIND_LEVEL && req_in_range) begin
                  lv_we = 1'b1;
                  lv_wa = req_vidx;
                  lv_wd = LEVEL_BITS'(req_chan.level);
               end
               if (req_chan.kind == KIND_FINISHED && req_in_range) begin
                  active_in[req_vidx] = 1'b0;
                  rel_in[req_vidx]    = 1'b0;
                  if (active_ff[req_vidx]) begin
                     cnt_in = cnt_ff - CW'(1);
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rdv_ff) begin
               if (match_hit) begin
                  match_found_in = 1'b1;
                  match_idx_in   = idx_d_ff;
               end
               if (free_hit) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_d_ff;
               end
               if (cur_act && id_rd_ff.age > newest_ff) begin
                  newest_in = id_rd_ff.age;
               end
               if (idx_d_ff == '0 || id_rd_ff.age < oldest_ff) begin
                  oldest_in     = id_rd_ff.age;
                  oldest_idx_in = idx_d_ff;
               end
               if (cur_act) begin
                  scan_cnt_in = scan_cnt_ff + CW'(1);
               end
            end
         end
         ST_QUIET: begin
            if (rdv_ff && cur_act && !skip_newest) begin
               if (cur_rel && (!qr_found_ff || lv_rd_ff < qr_lvl_ff ||
                               (lv_rd_ff == qr_lvl_ff && id_rd_ff.age < qr_age_ff))) begin
                  qr_found_in = 1'b1;
                  qr_idx_in   = idx_d_ff;
                  qr_lvl_in   = lv_rd_ff;
                  qr_age_in   = id_rd_ff.age;
               end
               if (!qa_found_ff || lv_rd_ff < qa_lvl_ff ||
                   (lv_rd_ff == qa_lvl_ff && id_rd_ff.age < qa_age_ff)) begin
                  qa_found_in = 1'b1;
                  qa_idx_in   = idx_d_ff;
                  qa_lvl_in   = lv_rd_ff;
                  qa_age_in   = id_rd_ff.age;
               end
            end
         end
         ST_START: begin
            priority if (match_found_ff) begin
               chosen_in = match_idx_ff;
               act_in    = ACT_RETRIGGER;
            end else if (free_found_ff) begin
               chosen_in = free_idx_ff;
               act_in    = ACT_FREE;
            end else if (qr_found_ff) begin
               chosen_in = qr_idx_ff;
               act_in    = ACT_STEAL_REL;
            end else if (qa_found_ff) begin
               chosen_in = qa_idx_ff;
               act_in    = ACT_STEAL_QT;
            end else begin
               chosen_in = oldest_idx_ff;
               act_in    = ACT_STEAL_OLD;
            end
            id_we                = 1'b1;
            lv_we                = 1'b1;
            lv_wa                = chosen_in;
            active_in[chosen_in] = 1'b1;
            rel_in[chosen_in]    = 1'b0;
            age_ctr_in           = age_next;
            cnt_in               = (!match_found_ff && free_found_ff) ?
                                   scan_cnt_ff + CW'(1) : scan_cnt_ff;
         end
         ST_RELEASE: begin
            if (rdv_ff && cur_act && !cur_rel && (kind_ff == KIND_ALL_OFF || id_match)) begin
               rel_in[idx_d_ff] = 1'b1;
               rel_cnt_in       = rel_cnt_ff + CW'(1);
            end
         end
         ST_RECOUNT: begin
            if (issue_ok) begin
               idx_in = idx_ff + CW'(1);
               if (active_ff[idx_ff[VW-1:0]]) begin
                  scan_cnt_in = scan_cnt_ff + CW'(1);
               end
            end else begin
               cnt_in = scan_cnt_ff;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_chosen_in = VOICE_W'(chosen_ff);
               rsp_action_in = act_ff;
               rsp_rel_in    = COUNT_W'(rel_cnt_ff);
               rsp_cnt_in    = COUNT_W'(cnt_ff);
            end
         end
         default: begin
            rdv_in = 1'b0;
         end
      endcase

      if (csr_fire) begin
         poly_in     = new_poly;
         idx_in      = '0;
         scan_cnt_in = '0;
         rdv_in      = 1'b0;
         for (int i = 0; i < MAX_VOICES; i++) begin
            if (i >= int'(new_poly)) begin
               active_in[i] = 1'b0;
               rel_in[i]    = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         ident_mem[chosen_in] <= id_wd;
      end
      id_rd_ff <= ident_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lv_we) begin
         level_mem[lv_wa] <= lv_wd;
      end
      lv_rd_ff <= level_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         poly_ff      <= CW'(POLY_RST);
         active_ff    <= '0;
         rel_ff       <= '0;
         age_ctr_ff   <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         poly_ff      <= poly_in;
         active_ff    <= active_in;
         rel_ff       <= rel_in;
         age_ctr_ff   <= age_ctr_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      note_ff        <= note_in;
      chan_ff        <= chan_in;
      idx_d_ff       <= idx_d_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      newest_ff      <= newest_in;
      oldest_ff      <= oldest_in;
      oldest_idx_ff  <= oldest_idx_in;
      scan_cnt_ff    <= scan_cnt_in;
      qr_found_ff    <= qr_found_in;
      qr_idx_ff      <= qr_idx_in;
      qr_lvl_ff      <= qr_lvl_in;
      qr_age_ff      <= qr_age_in;
      qa_found_ff    <= qa_found_in;
      qa_idx_ff      <= qa_idx_in;
      qa_lvl_ff      <= qa_lvl_in;
      qa_age_ff      <= qa_age_in;
      rel_cnt_ff     <= rel_cnt_in;
      chosen_ff      <= chosen_in;
      act_ff         <= act_in;
      rsp_chosen_ff  <= rsp_chosen_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_rel_ff     <= rsp_rel_in;
      rsp_cnt_ff     <= rsp_cnt_in;
   end

endmodule

FILE: sim/voice_allocator_with_stealing_unit_tb.sv
// ----------------------------------------------------------------------------
// Voice allocator with stealing: regression testbench
// Sends note, level and voice-finished requests through the request channel
// and checks every response against a cycle-free model of the voice table.
// The model covers allocation order, stealing and release counting. The run
// steps through several polyphony settings, the clamped extremes among them.
// Both channel sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voice_allocator_with_stealing_unit_tb;
   import vas_pkg::*;

   localparam int VOICE_SLOTS = 32;
   localparam int PHASE_ITEMS = 75;
   localparam int POOL_SIZE   = 8;
   localparam int REPORT_MAX  = 10;

   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [NOTE_W-1:0]  note;
      logic [VEL_W-1:0]   velocity;
      logic [CHAN_W-1:0]  channel;
      logic [VOICE_W-1:0] voice;
      logic [LEVEL_W-1:0] level;
   } note_event_type;

   typedef struct packed {
      logic [VOICE_W-1:0]  chosen_voice;
      logic [ACTION_W-1:0] action;
      logic [COUNT_W-1:0]  released_count;
      logic [COUNT_W-1:0]  active_count;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vas_req_if req_bus ();
   vas_rsp_if rsp_bus ();
   vas_csr_if csr_bus ();

   voice_allocator_with_stealing_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #6 clock = ~clock;

   // Shadow copy of the voice table.
   logic [CFG_W-1:0]   poly_reg;
   bit                 voice_on    [VOICE_SLOTS];
   bit                 voice_rel   [VOICE_SLOTS];
   logic [NOTE_W-1:0]  voice_key   [VOICE_SLOTS];
   logic [CHAN_W-1:0]  voice_chan  [VOICE_SLOTS];
   logic [31:0]        voice_stamp [VOICE_SLOTS];
   logic [LEVEL_W-1:0] voice_lvl   [VOICE_SLOTS];
   logic [31:0]        stamp_counter;

   note_event_type   note_backlog [$];
   alloc_result_type expected_outcomes [$];

   logic [NOTE_W-1:0] pool_note [POOL_SIZE];
   logic [CHAN_W-1:0] pool_chan [POOL_SIZE];

   bit req_fired, rsp_fired, req_busy;
   int req_gap, rsp_hold;
   int failures, responses, cfg_writes;
   int action_tally [8];
   note_event_type   launch_item, taken_item;
   alloc_result_type seen_rsp, due_rsp;

   function automatic int voices_enabled();
      if (poly_reg < 1) return 1;
      if (poly_reg > VOICE_SLOTS) return VOICE_SLOTS;
      return int'(poly_reg);
   endfunction

   function automatic void drop_voice(int i);
      voice_on[i]    = 1'b0;
      voice_rel[i]   = 1'b0;
      voice_key[i]   = '0;
      voice_chan[i]  = '0;
      voice_stamp[i] = '0;
      voice_lvl[i]   = '0;
   endfunction

   function automatic void set_polyphony(logic [CFG_W-1:0] value);
      int p;
      poly_reg = value;
      p = voices_enabled();
      for (int i = p; i < VOICE_SLOTS; i++) drop_voice(i);
   endfunction

   function automatic int quietest_voice(int p, bit need_release, logic [31:0] newest);
      int best;
      logic [LEVEL_W-1:0] best_lvl;
      logic [31:0] best_stamp;
      best = -1;
      best_lvl = '0;
      best_stamp = '0;
      for (int i = 0; i < p; i++) begin
         if (!voice_on[i]) continue;
         if (need_release && !voice_rel[i]) continue;
         if (voice_stamp[i] == newest && p > 1) continue;
         if (best < 0 || voice_lvl[i] < best_lvl ||
             (voice_lvl[i] == best_lvl && voice_stamp[i] < best_stamp)) begin
            best = i;
            best_lvl = voice_lvl[i];
            best_stamp = voice_stamp[i];
         end
      end
      return best;
   endfunction

   function automatic alloc_result_type predict_outcome(note_event_type ev);
      alloc_result_type r;
      int p, v, released, sounding;
      logic [31:0] newest, oldest;
      r = '0;
      p = voices_enabled();
      released = 0;
      sounding = 0;
      if (ev.kind == KIND_NOTE_ON && ev.velocity != 0) begin
         v = -1;
         for (int i = 0; i < p; i++)
            if (v < 0 && voice_on[i] && voice_key[i] == ev.note &&
                voice_chan[i] == ev.channel) begin
               v = i;
               r.action = ACT_RETRIGGER;
            end
         for (int i = 0; i < p; i++)
            if (v < 0 && !voice_on[i]) begin
               v = i;
               r.action = ACT_FREE;
            end
         if (v < 0) begin
            newest = '0;
            for (int i = 0; i < p; i++)
               if (voice_on[i] && voice_stamp[i] > newest) newest = voice_stamp[i];
            v = quietest_voice(p, 1'b1, newest);
            r.action = ACT_STEAL_REL;
            if (v < 0) begin
               v = quietest_voice(p, 1'b0, newest);
               r.action = ACT_STEAL_QT;
            end
            if (v < 0) begin
               v = 0;
               oldest = voice_stamp[0];
               for (int i = 1; i < p; i++)
                  if (voice_stamp[i] < oldest) begin
                     oldest = voice_stamp[i];
                     v = i;
                  end
               r.action = ACT_STEAL_OLD;
            end
         end
         voice_on[v]   = 1'b1;
         voice_rel[v]  = 1'b0;
         voice_key[v]  = ev.note;
         voice_chan[v] = ev.channel;
         voice_lvl[v]  = '0;
         if (stamp_counter != '1) stamp_counter++;
         voice_stamp[v] = stamp_counter;
         r.chosen_voice = VOICE_W'(v);
      end else if (ev.kind == KIND_NOTE_ON || ev.kind == KIND_NOTE_OFF ||
                   ev.kind == KIND_ALL_OFF) begin
         for (int i = 0; i < p; i++)
            if (voice_on[i] && (ev.kind == KIND_ALL_OFF ||
                (!voice_rel[i] && voice_key[i] == ev.note && voice_chan[i] == ev.channel))) begin
               if (!voice_rel[i]) released++;
               voice_rel[i] = 1'b1;
            end
      end else if (ev.kind == KIND_LEVEL) begin
         if (ev.voice < p) voice_lvl[ev.voice] = ev.level;
      end else if (ev.kind == KIND_FINISHED) begin
         if (ev.voice < p) begin
            voice_on[ev.voice]  = 1'b0;
            voice_rel[ev.voice] = 1'b0;
         end
      end
      for (int i = 0; i < p; i++)
         if (voice_on[i]) sounding++;
      r.released_count = COUNT_W'(released);
      r.active_count = COUNT_W'(sounding);
      return r;
   endfunction

   function automatic note_event_type random_event(int span);
      note_event_type ev;
      int pick, slot;
      ev.kind     = KIND_NOTE_ON;
      ev.note     = NOTE_W'($urandom_range(0, 127));
      ev.velocity = VEL_W'($urandom_range(1, 127));
      ev.channel  = CHAN_W'($urandom_range(0, 15));
      ev.voice    = VOICE_W'($urandom_range(0, 31));
      ev.level    = LEVEL_W'($urandom_range(0, 65535));
      slot = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 4) != 0) begin
         ev.note = pool_note[slot];
         ev.channel = pool_chan[slot];
      end
      if ($urandom_range(0, 4) != 0) ev.voice = VOICE_W'($urandom_range(0, span - 1));
      pick = $urandom_range(0, 9);
      if (pick == 0) ev.level = '0;
      else if (pick == 1) ev.level = '1;
      else if (pick < 5) ev.level = LEVEL_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         if ($urandom_range(0, 9) == 0) ev.velocity = '0;
      end else if (pick < 67) ev.kind = KIND_NOTE_OFF;
      else if (pick < 69) ev.kind = KIND_ALL_OFF;
      else if (pick < 87) ev.kind = KIND_LEVEL;
      else if (pick < 95) ev.kind = KIND_FINISHED;
      else ev.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      return ev;
   endfunction

   task automatic queue_event(input logic [KIND_W-1:0] kind, input int note, input int vel,
                              input int chan, input int voice, input int level);
      note_event_type ev;
      ev.kind     = kind;
      ev.note     = NOTE_W'(note);
      ev.velocity = VEL_W'(vel);
      ev.channel  = CHAN_W'(chan);
      ev.voice    = VOICE_W'(voice);
      ev.level    = LEVEL_W'(level);
      note_backlog = {note_backlog, ev};
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (note_backlog.size() != 0 || req_busy || expected_outcomes.size() != 0);
   endtask

   task automatic program_polyphony(input logic [CFG_W-1:0] value);
      wait_quiet();
      csr_bus.data <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock);
      while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      cfg_writes++;
   endtask

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_fired) begin
            req_busy = 1'b0;
            req_gap = $urandom_range(0, 10);
         end
         if (!req_busy) begin
            if (req_gap > 0 || note_backlog.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_bus.valid <= 1'b0;
            end else begin
               launch_item = note_backlog.pop_front();
               req_bus.kind     <= launch_item.kind;
               req_bus.note     <= launch_item.note;
               req_bus.velocity <= launch_item.velocity;
               req_bus.channel  <= launch_item.channel;
               req_bus.voice    <= launch_item.voice;
               req_bus.level    <= launch_item.level;
               req_bus.valid    <= 1'b1;
               req_busy = 1'b1;
            end
         end
      end
   end

   // Response acceptor.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fired) begin
            rsp_hold = $urandom_range(0, 10);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor and checker.
   always @(posedge clock) begin
      if (reset) begin
         req_fired = 1'b0;
         rsp_fired = 1'b0;
      end else begin
         req_fired = req_bus.valid && req_bus.ready;
         rsp_fired = rsp_bus.valid && rsp_bus.ready;
         if (csr_bus.valid && csr_bus.ready) set_polyphony(csr_bus.data);
         if (rsp_fired) begin
            seen_rsp.chosen_voice   = rsp_bus.chosen_voice;
            seen_rsp.action         = rsp_bus.action;
            seen_rsp.released_count = rsp_bus.released_count;
            seen_rsp.active_count   = rsp_bus.active_count;
            responses++;
            if (expected_outcomes.size() == 0) begin
               failures++;
               if (failures <= REPORT_MAX)
                  $display("%0t: response with none expected: voice %0d action %0d",
                           $realtime, seen_rsp.chosen_voice, seen_rsp.action);
            end else begin
               due_rsp = expected_outcomes.pop_front();
               if (seen_rsp.chosen_voice !== due_rsp.chosen_voice ||
                   seen_rsp.action !== due_rsp.action ||
                   seen_rsp.released_count !== due_rsp.released_count ||
                   seen_rsp.active_count !== due_rsp.active_count) begin
                  failures++;
                  if (failures <= REPORT_MAX)
                     $display({"%0t: response %0d mismatch: voice %0d/%0d action %0d/%0d ",
                               "released %0d/%0d active %0d/%0d (expected/actual)"},
                              $realtime, responses,
                              due_rsp.chosen_voice, seen_rsp.chosen_voice,
                              due_rsp.action, seen_rsp.action,
                              due_rsp.released_count, seen_rsp.released_count,
                              due_rsp.active_count, seen_rsp.active_count);
               end
            end
         end
         if (req_fired) begin
            taken_item.kind     = req_bus.kind;
            taken_item.note     = req_bus.note;
            taken_item.velocity = req_bus.velocity;
            taken_item.channel  = req_bus.channel;
            taken_item.voice    = req_bus.voice;
            taken_item.level    = req_bus.level;
            due_rsp = predict_outcome(taken_item);
            action_tally[due_rsp.action]++;
            expected_outcomes = {expected_outcomes, due_rsp};
         end
      end
   end

   initial begin
      #10_000_000;
      $display("voice_allocator_with_stealing_unit regression: fail");
      $finish;
   end

   initial begin
      int poly_plan [10] = '{63, 4, 32, 1, 8, 33, 3, 16, 2, 32};
      int span;
      req_bus.valid = 1'b0;
      req_bus.kind = '0;
      req_bus.note = '0;
      req_bus.velocity = '0;
      req_bus.channel = '0;
      req_bus.voice = '0;
      req_bus.level = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      poly_reg = CFG_W'(VOICE_SLOTS);
      for (int i = 0; i < VOICE_SLOTS; i++) drop_voice(i);
      stamp_counter = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full polyphony: free allocation, retrigger, velocity-zero release, all notes off.
      queue_event(KIND_NOTE_ON, 127, 127, 15, 0, 0);
      queue_event(KIND_NOTE_ON, 0, 1, 0, 0, 0);
      queue_event(KIND_NOTE_ON, 127, 64, 15, 0, 0);
      queue_event(KIND_NOTE_ON, 0, 0, 0, 0, 0);
      queue_event(KIND_NOTE_OFF, 0, 127, 0, 31, 65535);
      queue_event(KIND_NOTE_ON, 0, 100, 0, 0, 0);
      queue_event(KIND_LEVEL, 0, 0, 0, 0, 65535);
      queue_event(KIND_LEVEL, 127, 127, 15, 31, 0);
      queue_event(KIND_ALL_OFF, 0, 0, 0, 0, 0);
      queue_event(KIND_FINISHED, 0, 0, 0, 1, 0);
      queue_event(KIND_FINISHED, 0, 0, 0, 31, 0);
      queue_event(KIND_UNUSED_LO, 127, 127, 15, 31, 65535);
      queue_event(KIND_UNUSED_HI, 0, 0, 0, 0, 0);

      // Two voices: steal the quietest active voice, then a releasing one.
      program_polyphony(CFG_W'(2));
      queue_event(KIND_NOTE_ON, 10, 90, 3, 0, 0);
      queue_event(KIND_NOTE_ON, 20, 90, 4, 0, 0);
      queue_event(KIND_NOTE_ON, 30, 90, 5, 0, 0);
      queue_event(KIND_LEVEL, 0, 0, 0, 1, 5);
      queue_event(KIND_LEVEL, 0, 0, 0, 0, 256);
      queue_event(KIND_NOTE_OFF, 20, 0, 4, 0, 0);
      queue_event(KIND_NOTE_ON, 40, 90, 6, 0, 0);
      queue_event(KIND_LEVEL, 0, 0, 0, 2, 7);

      // A zero write clamps to one voice, where the newest voice is not protected.
      program_polyphony(CFG_W'(0));
      queue_event(KIND_NOTE_ON, 50, 90, 7, 0, 0);
      queue_event(KIND_NOTE_ON, 50, 90, 7, 0, 0);
      queue_event(KIND_NOTE_OFF, 50, 0, 7, 0, 0);
      queue_event(KIND_NOTE_ON, 51, 90, 8, 0, 0);
      queue_event(KIND_FINISHED, 0, 0, 0, 1, 0);

      foreach (poly_plan[ph]) begin
         program_polyphony(CFG_W'(poly_plan[ph]));
         span = poly_plan[ph] < 1 ? 1 : (poly_plan[ph] > VOICE_SLOTS ? VOICE_SLOTS
                                                                    : poly_plan[ph]);
         for (int k = 0; k < POOL_SIZE; k++) begin
            pool_note[k] = NOTE_W'($urandom_range(0, 127));
            pool_chan[k] = CHAN_W'($urandom_range(0, 15));
         end
         // Fill every voice first so that stealing is reached early.
         for (int k = 0; k < span + 4; k++)
            queue_event(KIND_NOTE_ON, $urandom_range(0, 127), $urandom_range(1, 127),
                        $urandom_range(0, 15), $urandom_range(0, 31),
                        $urandom_range(0, 65535));
         for (int k = span + 4; k < PHASE_ITEMS; k++)
            note_backlog = {note_backlog, random_event(span)};
      end

      wait_quiet();
      repeat (80) @(posedge clock);
      failures += expected_outcomes.size();
      $display("Checked %0d responses over %0d polyphony settings.", responses, cfg_writes + 1);
      $display("Allocations: %0d free, %0d retrigger, %0d steal releasing, %0d steal quietest.",
               action_tally[ACT_FREE], action_tally[ACT_RETRIGGER],
               action_tally[ACT_STEAL_REL], action_tally[ACT_STEAL_QT]);
      if (failures == 0) begin
         $display("voice_allocator_with_stealing_unit regression: pass");
      end else begin
         $display("voice_allocator_with_stealing_unit regression: fail");
      end
      $finish;
   end

endmodule
